// ===== hdl/mec_pkg.sv =====
// Shared types, operation codes and control structs for the multiset equality checker.
package mec_pkg;

	typedef logic [1:0]         op_t;
	typedef logic signed [31:0] element_t;

	localparam op_t OP_CLEAR    = 2'd0;
	localparam op_t OP_APPEND_A = 2'd1;
	localparam op_t OP_APPEND_B = 2'd2;
	localparam op_t OP_EVALUATE = 2'd3;

	typedef struct packed {
		logic clear_sets;
		logic append_a;
		logic append_b;
		logic clear_i;
		logic inc_i;
		logic sel_i;
		logic load_value;
		logic clear_scan;
		logic scan_issue;
		logic emit;
		logic verdict;
	} mec_cmd_t;

	typedef struct packed {
		logic sizes_ok;
		logic i_last;
		logic k_last;
		logic counts_equal;
	} mec_status_t;

endpackage

// ===== hdl/multiset_equality_checker.sv =====
// Top level of the multiset equality checker: controller plus datapath.
// Transactions are taken when start is high and busy is low. Clear and the two appends give
// no result; back-to-back appends run at one per cycle. An evaluate with unequal or empty
// sets answers in the next cycle without raising busy. Otherwise the controller walks store
// A: for each of its n entries it fetches the value, then scans both stores at the same
// index, counting matches, and keeps busy high until the walk ends, early when a count
// mismatch is found. The verdict appears on sets_equal and overflow_seen for one cycle with
// done high; the receiver cannot stall it.
module multiset_equality_checker #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mec_pkg::op_t      operation,
	input  mec_pkg::element_t element_value,
	output logic              done,
	output logic              sets_equal,
	output logic              overflow_seen
);
	import mec_pkg::*;

	mec_cmd_t    cmd;
	mec_status_t status;

	mec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	mec_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.element_value (element_value),
		.status        (status),
		.done          (done),
		.sets_equal    (sets_equal),
		.overflow_seen (overflow_seen)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while evaluation still running");

endmodule

// ===== hdl/mec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/mec_datapath.sv =====
// Datapath: both stores, fill counters, overflow flag, scan counters and result register.
module mec_datapath #(
	parameter int MAX_ELEMENTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mec_pkg::mec_cmd_t   cmd,
	input  mec_pkg::element_t   element_value,
	output mec_pkg::mec_status_t status,
	output logic                done,
	output logic                sets_equal,
	output logic                overflow_seen
);
	import mec_pkg::*;

	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
	localparam logic [FILL_W-1:0] FULL = FILL_W'(MAX_ELEMENTS);
	localparam logic [FILL_W-1:0] ONE  = FILL_W'(1);

	logic [FILL_W-1:0] fill_a_q, fill_b_q;
	logic              ovf_q;
	logic [FILL_W-1:0] i_q, k_q;
	logic [FILL_W-1:0] cnt_a_q, cnt_b_q;
	logic              cmp_valid_s1;
	element_t          value_q;
	logic              done_q, sets_equal_q, overflow_seen_q;

	logic              full_a, full_b, we_a, we_b;
	logic [ADDR_W-1:0] rd_addr_a;
	element_t          rdata_a, rdata_b;

	assign full_a = (fill_a_q == FULL);
	assign full_b = (fill_b_q == FULL);
	assign we_a   = cmd.append_a && !full_a;
	assign we_b   = cmd.append_b && !full_b;

	// Store A is read at the outer index while fetching a value, else at the scan index.
	assign rd_addr_a = cmd.sel_i ? i_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];

	mec_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (fill_a_q[ADDR_W-1:0]),
		.wdata (element_value),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	mec_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (fill_b_q[ADDR_W-1:0]),
		.wdata (element_value),
		.raddr (k_q[ADDR_W-1:0]),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_a_q <= '0;
			fill_b_q <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.clear_sets) begin
			fill_a_q <= '0;
			fill_b_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (cmd.append_a) begin
				if (full_a) begin
					ovf_q <= 1'b1;
				end else begin
					fill_a_q <= fill_a_q + ONE;
				end
			end
			if (cmd.append_b) begin
				if (full_b) begin
					ovf_q <= 1'b1;
				end else begin
					fill_b_q <= fill_b_q + ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			k_q          <= '0;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			if (cmd.clear_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + ONE;
			end
			cmp_valid_s1 <= cmd.scan_issue;
			if (cmd.clear_scan) begin
				k_q     <= '0;
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end else begin
				if (cmd.scan_issue) begin
					k_q <= k_q + ONE;
				end
				// Read data is registered in the RAMs, so matches are counted while cmp_valid_s1 is set.
				if (cmp_valid_s1) begin
					cnt_a_q <= cnt_a_q + FILL_W'(rdata_a == value_q);
					cnt_b_q <= cnt_b_q + FILL_W'(rdata_b == value_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			value_q <= rdata_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q          <= 1'b0;
			sets_equal_q    <= 1'b0;
			overflow_seen_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.emit) begin
				sets_equal_q    <= cmd.verdict;
				overflow_seen_q <= ovf_q;
			end
		end
	end

	assign status.sizes_ok     = (fill_a_q == fill_b_q) && (fill_a_q != '0);
	assign status.i_last       = ((i_q + ONE) == fill_a_q);
	assign status.k_last       = ((k_q + ONE) == fill_a_q);
	assign status.counts_equal = (cnt_a_q == cnt_b_q);

	assign done          = done_q;
	assign sets_equal    = sets_equal_q;
	assign overflow_seen = overflow_seen_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_a_q <= FULL && fill_b_q <= FULL)
		else $error("fill count beyond capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= k_q && cnt_b_q <= k_q)
		else $error("match count exceeds scanned entries");

endmodule

// ===== hdl/mec_ctrl.sv =====
// Controller state machine: decodes transactions and sequences the evaluation walk.
module mec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mec_pkg::op_t         operation,
	input  mec_pkg::mec_status_t status,
	output mec_pkg::mec_cmd_t    cmd,
	output logic                 busy
);
	import mec_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_LATCH = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;

	logic [2:0] state_q, state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_CLEAR:    cmd.clear_sets = 1'b1;
						OP_APPEND_A: cmd.append_a   = 1'b1;
						OP_APPEND_B: cmd.append_b   = 1'b1;
						OP_EVALUATE: begin
							// Unequal or empty sizes give a false verdict without starting the walk.
							if (status.sizes_ok) begin
								cmd.clear_i = 1'b1;
								state_d     = ST_FETCH;
							end else begin
								cmd.emit    = 1'b1;
								cmd.verdict = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.sel_i = 1'b1;
				state_d   = ST_LATCH;
			end
			ST_LATCH: begin
				cmd.load_value = 1'b1;
				cmd.clear_scan = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!status.counts_equal) begin
					cmd.emit    = 1'b1;
					cmd.verdict = 1'b0;
					state_d     = ST_IDLE;
				end else if (status.i_last) begin
					cmd.emit    = 1'b1;
					cmd.verdict = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = ST_FETCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_walk_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> status.sizes_ok)
		else $error("evaluation running with mismatched or empty sets");

	a_check_follows_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_CHECK)
		else $error("drain not followed by count check");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the multiset equality checker.
`timescale 1ns / 1ps

module testbench;
	import mec_pkg::*;

	localparam int CAPACITY    = 256;
	localparam int ITEM_TARGET = 1450;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE      = 16;

	typedef struct packed {
		logic equal;
		logic ovf;
	} verdict_t;

	// Tracks both stores as the block should see them and queues the verdicts it owes.
	class verdict_board;
		element_t set_a[$];
		element_t set_b[$];
		bit       overflow;
		int       cap;
		verdict_t verdict_q[$];
		int       mismatches;

		function new(int capacity);
			cap        = capacity;
			overflow   = 1'b0;
			mismatches = 0;
		endfunction

		function bit is_permutation();
			int hits_a;
			int hits_b;
			if (set_a.size() != set_b.size() || set_a.size() == 0)
				return 1'b0;
			foreach (set_a[i]) begin
				hits_a = 0;
				hits_b = 0;
				foreach (set_a[k])
					if (set_a[k] == set_a[i])
						hits_a++;
				foreach (set_b[k])
					if (set_b[k] == set_a[i])
						hits_b++;
				if (hits_a != hits_b)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_item(op_t op, element_t value);
			verdict_t v;
			case (op)
				OP_CLEAR: begin
					set_a.delete();
					set_b.delete();
					overflow = 1'b0;
				end
				OP_APPEND_A: begin
					if (set_a.size() < cap)
						set_a.push_back(value);
					else
						overflow = 1'b1;
				end
				OP_APPEND_B: begin
					if (set_b.size() < cap)
						set_b.push_back(value);
					else
						overflow = 1'b1;
				end
				OP_EVALUATE: begin
					v.equal = is_permutation();
					v.ovf   = overflow;
					verdict_q.push_back(v);
				end
			endcase
		endfunction

		function void check_verdict(logic equal, logic ovf);
			verdict_t v;
			if (verdict_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected verdict: equal=%0b overflow=%0b", equal, ovf);
				mismatches++;
			end else begin
				v = verdict_q.pop_front();
				if (v.equal !== equal || v.ovf !== ovf) begin
					if (mismatches < 10)
						$display("mismatch: exp equal=%0b ovf=%0b, got equal=%0b ovf=%0b",
							v.equal, v.ovf, equal, ovf);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	logic     start         = 1'b0;
	op_t      operation     = OP_CLEAR;
	element_t element_value = '0;
	logic     busy;
	logic     done;
	logic     sets_equal;
	logic     overflow_seen;

	verdict_board sb;
	int           items_sent  = 0;
	int           cycle_count = 0;
	bit           no_idle     = 1'b0;

	multiset_equality_checker #(
		.MAX_ELEMENTS(CAPACITY)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.element_value(element_value),
		.done         (done),
		.sets_equal   (sets_equal),
		.overflow_seen(overflow_seen)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_verdict(sets_equal, overflow_seen);
	end

	// Holds the transaction until the block takes it, then sometimes idles for a random gap.
	task automatic send(op_t op, element_t value);
		int gap;
		int r;
		start         <= 1'b1;
		operation     <= op;
		element_value <= value;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(op, value);
		items_sent++;
		r   = $urandom_range(0, 99);
		gap = 0;
		if (!no_idle) begin
			if (r >= 95)
				gap = $urandom_range(8, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.verdict_q.size() != 0);
	endtask

	// Loads A and a shuffled copy into B in random interleaving, optionally spoils one of the
	// two sets, then asks for the verdict.
	task automatic run_wellformed(int n, bit intact);
		element_t vals_a[$];
		element_t vals_b[$];
		element_t pool[4];
		element_t tmp;
		int       j;
		int       ia;
		int       ib;
		bit       dup;
		dup     = $urandom_range(0, 1);
		pool[0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		pool[1] = $urandom();
		pool[2] = $urandom();
		pool[3] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
		if (n > 24 || sb.set_a.size() > 24 || sb.set_b.size() > 24 ||
				$urandom_range(0, 9) != 0)
			send(OP_CLEAR, $urandom());
		for (j = 0; j < n; j++) begin
			tmp = dup ? pool[$urandom_range(0, 3)] : element_t'($urandom());
			vals_a.push_back(tmp);
		end
		vals_b = vals_a;
		for (j = n - 1; j > 0; j--) begin
			ia        = $urandom_range(0, j);
			tmp       = vals_b[j];
			vals_b[j] = vals_b[ia];
			vals_b[ia] = tmp;
		end
		if (!intact) begin
			tmp = dup ? pool[$urandom_range(0, 3)] : element_t'($urandom());
			j   = $urandom_range(0, n - 1);
			case ($urandom_range(0, 3))
				0: vals_b[j] = tmp;
				1: void'(vals_b.pop_back());
				2: vals_b.push_back(tmp);
				default: vals_a[j] = tmp;
			endcase
		end
		ia = 0;
		ib = 0;
		while (ia < vals_a.size() || ib < vals_b.size()) begin
			if (ib >= vals_b.size() || (ia < vals_a.size() && $urandom_range(0, 1))) begin
				send(OP_APPEND_A, vals_a[ia]);
				ia++;
			end else begin
				send(OP_APPEND_B, vals_b[ib]);
				ib++;
			end
		end
		send(OP_EVALUATE, $urandom());
		if ($urandom_range(0, 7) == 0)
			send(OP_EVALUATE, $urandom());
	endtask

	initial begin
		int seq_index;
		int big_index;
		int n;
		sb = new(CAPACITY);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty sets, then extreme values that differ, then a minimal match.
		send(OP_EVALUATE, $urandom());
		send(OP_APPEND_A, 32'h8000_0000);
		send(OP_APPEND_B, 32'h7fff_ffff);
		send(OP_EVALUATE, $urandom());
		send(OP_CLEAR, $urandom());
		send(OP_APPEND_A, 32'hffff_ffff);
		send(OP_APPEND_B, 32'hffff_ffff);
		send(OP_EVALUATE, $urandom());
		// Size mismatch, then sizes equal again.
		send(OP_APPEND_B, 32'h0000_0000);
		send(OP_EVALUATE, $urandom());
		send(OP_APPEND_A, 32'h0000_0000);
		send(OP_EVALUATE, $urandom());
		// Same distinct values but different multiplicities.
		send(OP_CLEAR, $urandom());
		send(OP_APPEND_A, 32'd5);
		send(OP_APPEND_A, 32'd5);
		send(OP_APPEND_A, 32'd7);
		send(OP_APPEND_B, 32'd5);
		send(OP_APPEND_B, 32'd7);
		send(OP_APPEND_B, 32'd7);
		send(OP_EVALUATE, $urandom());
		wait_drained();

		// Fill both stores, then push one more into each so the verdict reports overflow.
		run_wellformed(CAPACITY, 1'b1);
		send(OP_APPEND_A, $urandom());
		send(OP_APPEND_B, $urandom());
		send(OP_EVALUATE, $urandom());
		send(OP_CLEAR, $urandom());
		send(OP_EVALUATE, $urandom());
		wait_drained();

		seq_index = 0;
		big_index = $urandom_range(10, 30);
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 9) < 3);
			if (seq_index == big_index) begin
				run_wellformed($urandom_range(CAPACITY - 6, CAPACITY + 6), $urandom_range(0, 1));
			end else if ($urandom_range(0, 3) == 0) begin
				if (sb.set_a.size() > 24 || sb.set_b.size() > 24)
					send(OP_CLEAR, $urandom());
				repeat ($urandom_range(1, 8))
					send(op_t'($urandom_range(0, 3)), $urandom());
			end else begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
				run_wellformed(n, $urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			seq_index++;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mec_pkg.sv
hdl/mec_ram.sv
hdl/mec_datapath.sv
hdl/mec_ctrl.sv
hdl/multiset_equality_checker.sv
sim/testbench.sv
